// ===== hdl/grid_vertex_normals_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef GRID_VERTEX_NORMALS_MACROS_SVH
`define GRID_VERTEX_NORMALS_MACROS_SVH
`ifndef SYNTHESIS
`define GVN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gvn assertion failed");
`define GVN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gvn assertion failed");
`else
`define GVN_ASSERT(lbl, clk, rst_n, prop)
`define GVN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/gvn_pkg.sv =====
`timescale 1ns / 1ps
package gvn_pkg;
  localparam int MAX_COLS_DEF = 1024;
  localparam int ROW_W = 16;
  localparam int GCOL_W = 11;
  localparam int OCOL_W = 10;
  localparam int COL_W = 13;
  localparam int CRD_W = 32;
  localparam int NRM_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam int EDG_W = 33;
  localparam int PRD_W = 66;
  localparam int ACC_W = 72;
  localparam int SM_W = 30;
  localparam int SUM_W = 62;
  localparam int LEN_W = 31;
  localparam logic [NRM_W-1:0] NRM_ONE = 16'd16384;

  typedef struct packed {
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic signed [CRD_W-1:0] pos_z;
  } vtx_t;

  typedef struct packed {
    logic [ROW_W-1:0]        out_row;
    logic [OCOL_W-1:0]       out_col;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
    logic                    degenerate;
    logic                    last_of_item;
  } nrm_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [1:0]       slot;
    logic [ROW_W-1:0] rows_eff;
    logic [COL_W:0]   cols_eff;
    logic             emit_up;
    logic             emit_left;
    logic             emit_self;
  } job_t;

  // cross product term m: {a component, b component}; odd terms are subtracted
  function automatic logic [3:0] xp_sel(input logic [2:0] m);
    logic [3:0] r;
    unique case (m)
      3'd0:    r = {2'd1, 2'd2};
      3'd1:    r = {2'd2, 2'd1};
      3'd2:    r = {2'd2, 2'd0};
      3'd3:    r = {2'd0, 2'd2};
      3'd4:    r = {2'd0, 2'd1};
      3'd5:    r = {2'd1, 2'd0};
      default: r = 4'd0;
    endcase
    return r;
  endfunction
endpackage

// ===== hdl/gvn_ram.sv =====
`timescale 1ns / 1ps
module gvn_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  assign rdata = rd_r;
endmodule

// ===== hdl/gvn_queue.sv =====
`timescale 1ns / 1ps
module gvn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gvn_pkg::job_t push_data,
  input  logic          pop,
  output gvn_pkg::job_t pop_data,
  output logic          empty,
  output logic          full
);
  gvn_pkg::job_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign pop_data = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wp_r <= ~wp_r;
      end
      if (pop && !empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// ===== hdl/gvn_front.sv =====
`timescale 1ns / 1ps
module gvn_front #(
  parameter int MAX_COLS = gvn_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gvn_pkg::vtx_t                      in_data,
  input  logic                               cfg_we,
  input  logic [gvn_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [gvn_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                               hold,
  output logic                               q_push,
  output gvn_pkg::job_t                      q_job,
  output logic                               ram_we,
  output logic [$clog2(3*MAX_COLS)-1:0]      ram_waddr,
  output logic [3*gvn_pkg::CRD_W-1:0]        ram_wdata
);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = $clog2(3*MAX_COLS);

  logic [gvn_pkg::ROW_W-1:0]  rows_r, rows_nxt, row_r, row_nxt, rows_eff;
  logic [gvn_pkg::GCOL_W-1:0] cols_r, cols_nxt;
  logic [CW-1:0]              col_r, col_nxt;
  logic [1:0]                 slot_r, slot_nxt;
  logic [CW:0]                cols_eff;
  logic                       in_acc, last_row, last_col;
  logic [AW-1:0]              base;

  assign in_stall = hold;
  assign in_acc   = in_valid && !in_stall;
  assign rows_eff = (rows_r == '0) ? gvn_pkg::ROW_W'(1) : rows_r;

  always_comb begin
    if (cols_r == '0) begin
      cols_eff = (CW+1)'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      cols_eff = (CW+1)'(MAX_COLS);
    end else begin
      cols_eff = (CW+1)'(cols_r);
    end
  end

  assign last_row = ({1'b0, row_r} + 17'd1) == {1'b0, rows_eff};
  assign last_col = ({1'b0, col_r} + (CW+1)'(1)) == cols_eff;

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    slot_nxt = slot_r;
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        gvn_pkg::REG_GRID_ROWS: begin
          rows_nxt = cfg_wdata;
          row_nxt  = '0;
          col_nxt  = '0;
          slot_nxt = '0;
        end
        gvn_pkg::REG_GRID_COLS: begin
          cols_nxt = cfg_wdata[gvn_pkg::GCOL_W-1:0];
          row_nxt  = '0;
          col_nxt  = '0;
          slot_nxt = '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = row_r + 16'd1;
          slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= gvn_pkg::ROW_W'(1);
      cols_r <= gvn_pkg::GCOL_W'(1);
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // row r lives in slot r mod 3
  always_comb begin
    unique case (slot_r)
      2'd0:    base = '0;
      2'd1:    base = AW'(MAX_COLS);
      default: base = AW'(2*MAX_COLS);
    endcase
  end

  assign ram_we    = in_acc;
  assign ram_waddr = base + AW'(col_r);
  assign ram_wdata = in_data;

  assign q_push          = in_acc;
  assign q_job.row       = row_r;
  assign q_job.col       = gvn_pkg::COL_W'(col_r);
  assign q_job.slot      = slot_r;
  assign q_job.rows_eff  = rows_eff;
  assign q_job.cols_eff  = (gvn_pkg::COL_W+1)'(cols_eff);
  assign q_job.emit_up   = (row_r != '0);
  assign q_job.emit_left = last_row && (col_r != '0);
  assign q_job.emit_self = last_row && last_col;
endmodule

// ===== hdl/gvn_back.sv =====
`timescale 1ns / 1ps
`include "grid_vertex_normals_macros.svh"
module gvn_back #(
  parameter int MAX_COLS = gvn_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  gvn_pkg::job_t                 q_data,
  output logic                          q_pop,
  output logic                          busy,
  output logic [$clog2(3*MAX_COLS)-1:0] ram_raddr,
  input  logic [3*gvn_pkg::CRD_W-1:0]   ram_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gvn_pkg::nrm_t                 out_data
);
  localparam int AW = $clog2(3*MAX_COLS);
  localparam int CL = gvn_pkg::COL_W;
  localparam int EW = gvn_pkg::EDG_W;
  localparam int PW = gvn_pkg::PRD_W;
  localparam int XW = gvn_pkg::ACC_W;
  localparam int SW = gvn_pkg::SM_W;
  localparam int QW = gvn_pkg::SUM_W;
  localparam int LW = gvn_pkg::LEN_W;
  localparam int NW = gvn_pkg::NRM_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PICK = 4'd1;
  localparam logic [3:0] ST_LOAD = 4'd2;
  localparam logic [3:0] ST_EDGE = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_TRIP = 4'd6;
  localparam logic [3:0] ST_ABS  = 4'd7;
  localparam logic [3:0] ST_NORM = 4'd8;
  localparam logic [3:0] ST_SQM  = 4'd9;
  localparam logic [3:0] ST_SQA  = 4'd10;
  localparam logic [3:0] ST_SQRT = 4'd11;
  localparam logic [3:0] ST_DIVI = 4'd12;
  localparam logic [3:0] ST_DIVS = 4'd13;
  localparam logic [3:0] ST_DIVE = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  logic [3:0]                st_r;
  gvn_pkg::job_t             job_r;
  logic [2:0]                pend_r;
  logic [gvn_pkg::ROW_W-1:0] cr_r;
  logic [CL-1:0]             cc_r;
  logic [1:0]                cs_r;
  logic [3:0]                has_r;
  logic                      last_r, deg_r;
  logic [2:0]                ld_r;
  gvn_pkg::vtx_t             v_r [5];
  logic signed [EW-1:0]      e_r [4][3];
  logic [1:0]                pk_r, sq_i_r, d_i_r;
  logic [2:0]                pm_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [XW-1:0]      acc_r [3];
  logic [XW-1:0]             mag_r [3];
  logic [2:0]                neg_r;
  logic [QW-1:0]             sum_r, sv_r;
  logic [LW+1:0]             rem_r;
  logic [LW-1:0]             root_r;
  logic [4:0]                it_r;
  logic [31:0]               drem_r;
  logic [15:0]               dnum_r, q_r;
  logic [3:0]                dit_r;
  logic signed [NW-1:0]      nrm_r [3];
  logic                      out_valid_r;
  gvn_pkg::nrm_t             out_data_r;

  logic signed [gvn_pkg::CRD_W-1:0] vc [5][3];
  logic signed [EW-1:0]      mul_a, mul_b;
  logic [3:0]                sel;
  logic [1:0]                up_slot, dn_slot, rd_slot;
  logic [CL-1:0]             rd_col;
  logic [AW-1:0]             rd_base;
  logic [XW-1:0]             mor;
  logic signed [XW-1:0]      term;
  logic [QW-1:0]             sum_add;
  logic [LW+3:0]             rem2;
  logic [LW+3:0]             trial;
  logic [44:0]               num;
  logic [32:0]               dr2;
  logic [15:0]               nq;
  logic                      out_free;

  assign busy      = (st_r != ST_IDLE);
  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      vc[k][0] = v_r[k].pos_x;
      vc[k][1] = v_r[k].pos_y;
      vc[k][2] = v_r[k].pos_z;
    end
  end

  assign up_slot = (cs_r == 2'd0) ? 2'd2 : cs_r - 2'd1;
  assign dn_slot = (cs_r == 2'd2) ? 2'd0 : cs_r + 2'd1;

  // read order: center, up, left, down, right; a missing neighbor reads the center
  always_comb begin
    rd_slot = cs_r;
    rd_col  = cc_r;
    unique case (ld_r)
      3'd1: if (has_r[0]) rd_slot = up_slot;
      3'd2: if (has_r[1]) rd_col = cc_r - CL'(1);
      3'd3: if (has_r[2]) rd_slot = dn_slot;
      3'd4: if (has_r[3]) rd_col = cc_r + CL'(1);
      default: ;
    endcase
    unique case (rd_slot)
      2'd0:    rd_base = '0;
      2'd1:    rd_base = AW'(MAX_COLS);
      default: rd_base = AW'(2*MAX_COLS);
    endcase
  end
  assign ram_raddr = rd_base + AW'(rd_col);

  // one shared multiplier: cross product terms, then squares
  assign sel = gvn_pkg::xp_sel(pm_r);
  always_comb begin
    if (st_r == ST_SQM) begin
      mul_a = $signed({3'b000, mag_r[sq_i_r][XW-1 -: SW]});
      mul_b = mul_a;
    end else begin
      mul_a = e_r[pk_r][sel[3:2]];
      mul_b = e_r[pk_r + 2'd1][sel[1:0]];
    end
  end

  assign mor     = mag_r[0] | mag_r[1] | mag_r[2];
  assign term    = {{(XW-PW){prod_r[PW-1]}}, prod_r};
  assign sum_add = sum_r + prod_r[QW-1:0];
  assign rem2    = {rem_r, sv_r[QW-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign num     = {1'b0, mag_r[d_i_r][XW-1 -: SW], 14'd0} + 45'(root_r >> 1);
  assign dr2     = {drem_r, dnum_r[15]};
  assign nq      = (q_r > gvn_pkg::NRM_ONE) ? gvn_pkg::NRM_ONE : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            job_r  <= q_data;
            pend_r <= {q_data.emit_self, q_data.emit_left, q_data.emit_up};
            st_r   <= ST_PICK;
          end
        end
        ST_PICK: begin
          priority if (pend_r[0]) begin
            cr_r      <= job_r.row - 16'd1;
            cc_r      <= job_r.col;
            cs_r      <= (job_r.slot == 2'd0) ? 2'd2 : job_r.slot - 2'd1;
            has_r     <= {({1'b0, job_r.col} + 14'd1) < job_r.cols_eff, 1'b1,
                          job_r.col != '0, (job_r.row - 16'd1) != '0};
            last_r    <= !(pend_r[1] || pend_r[2]);
            pend_r[0] <= 1'b0;
            ld_r      <= '0;
            st_r      <= ST_LOAD;
          end else if (pend_r[1] || pend_r[2]) begin
            cr_r   <= job_r.row;
            cc_r   <= pend_r[1] ? job_r.col - CL'(1) : job_r.col;
            cs_r   <= job_r.slot;
            has_r  <= {pend_r[1] || (({1'b0, job_r.col} + 14'd1) < job_r.cols_eff),
                       ({1'b0, job_r.row} + 17'd1) < {1'b0, job_r.rows_eff},
                       pend_r[1] ? ((job_r.col - CL'(1)) != '0) : (job_r.col != '0),
                       job_r.row != '0};
            last_r <= pend_r[1] ? !pend_r[2] : 1'b1;
            if (pend_r[1]) begin
              pend_r[1] <= 1'b0;
            end else begin
              pend_r[2] <= 1'b0;
            end
            ld_r   <= '0;
            st_r   <= ST_LOAD;
          end else begin
            st_r <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          if (ld_r != 3'd0) begin
            v_r[ld_r - 3'd1] <= ram_rdata;
          end
          ld_r <= ld_r + 3'd1;
          if (ld_r == 3'd5) begin
            st_r <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          for (int k = 0; k < 4; k++) begin
            for (int d = 0; d < 3; d++) begin
              e_r[k][d] <= {vc[k+1][d][31], vc[k+1][d]} - {vc[0][d][31], vc[0][d]};
            end
          end
          for (int d = 0; d < 3; d++) begin
            acc_r[d] <= '0;
          end
          pk_r <= '0;
          pm_r <= '0;
          st_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= mul_a * mul_b;
          st_r   <= ST_ACC;
        end
        ST_ACC: begin
          if (has_r[pk_r] && has_r[pk_r + 2'd1]) begin
            acc_r[pm_r[2:1]] <= acc_r[pm_r[2:1]] + (pm_r[0] ? -term : term);
          end
          if (pm_r == 3'd5) begin
            pm_r <= '0;
            pk_r <= pk_r + 2'd1;
            st_r <= (pk_r == 2'd3) ? ST_TRIP : ST_MUL;
          end else begin
            pm_r <= pm_r + 3'd1;
            st_r <= ST_MUL;
          end
        end
        ST_TRIP: begin
          acc_r[0] <= acc_r[0] + (acc_r[0] <<< 1);
          acc_r[2] <= acc_r[2] + (acc_r[2] <<< 1);
          st_r     <= ST_ABS;
        end
        ST_ABS: begin
          for (int d = 0; d < 3; d++) begin
            neg_r[d] <= acc_r[d][XW-1];
            mag_r[d] <= acc_r[d][XW-1] ? XW'(-acc_r[d]) : XW'(acc_r[d]);
          end
          deg_r <= 1'b0;
          st_r  <= ST_NORM;
        end
        ST_NORM: begin
          // shift until the top bit of the largest magnitude reaches the msb
          priority if (mor == '0) begin
            deg_r <= 1'b1;
            for (int d = 0; d < 3; d++) begin
              nrm_r[d] <= '0;
            end
            st_r <= ST_OUT;
          end else if (mor[XW-1 -: 8] == 8'd0) begin
            for (int d = 0; d < 3; d++) begin
              mag_r[d] <= mag_r[d] << 8;
            end
          end else if (!mor[XW-1]) begin
            for (int d = 0; d < 3; d++) begin
              mag_r[d] <= mag_r[d] << 1;
            end
          end else begin
            sq_i_r <= '0;
            sum_r  <= '0;
            st_r   <= ST_SQM;
          end
        end
        ST_SQM: begin
          prod_r <= mul_a * mul_b;
          st_r   <= ST_SQA;
        end
        ST_SQA: begin
          sum_r <= sum_add;
          if (sq_i_r == 2'd2) begin
            sv_r   <= sum_add;
            rem_r  <= '0;
            root_r <= '0;
            it_r   <= '0;
            st_r   <= ST_SQRT;
          end else begin
            sq_i_r <= sq_i_r + 2'd1;
            st_r   <= ST_SQM;
          end
        end
        ST_SQRT: begin
          if (rem2 >= trial) begin
            rem_r  <= (LW+2)'(rem2 - trial);
            root_r <= {root_r[LW-2:0], 1'b1};
          end else begin
            rem_r  <= (LW+2)'(rem2);
            root_r <= {root_r[LW-2:0], 1'b0};
          end
          sv_r <= sv_r << 2;
          it_r <= it_r + 5'd1;
          if (it_r == 5'd30) begin
            d_i_r <= '0;
            st_r  <= ST_DIVI;
          end
        end
        ST_DIVI: begin
          drem_r <= 32'(num[44:16]);
          dnum_r <= num[15:0];
          q_r    <= '0;
          dit_r  <= '0;
          st_r   <= ST_DIVS;
        end
        ST_DIVS: begin
          if (dr2 >= {2'b00, root_r}) begin
            drem_r <= 32'(dr2 - {2'b00, root_r});
            q_r    <= {q_r[14:0], 1'b1};
          end else begin
            drem_r <= dr2[31:0];
            q_r    <= {q_r[14:0], 1'b0};
          end
          dnum_r <= dnum_r << 1;
          dit_r  <= dit_r + 4'd1;
          if (dit_r == 4'd15) begin
            st_r <= ST_DIVE;
          end
        end
        ST_DIVE: begin
          nrm_r[d_i_r] <= neg_r[d_i_r] ? -$signed(nq) : $signed(nq);
          if (d_i_r == 2'd2) begin
            st_r <= ST_OUT;
          end else begin
            d_i_r <= d_i_r + 2'd1;
            st_r  <= ST_DIVI;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r             <= 1'b1;
            out_data_r.out_row      <= cr_r;
            out_data_r.out_col      <= gvn_pkg::OCOL_W'(cc_r);
            out_data_r.norm_x       <= nrm_r[0];
            out_data_r.norm_y       <= nrm_r[1];
            out_data_r.norm_z       <= nrm_r[2];
            out_data_r.degenerate   <= deg_r;
            out_data_r.last_of_item <= last_r;
            st_r                    <= ST_PICK;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `GVN_ASSERT(a_len_nonzero, clk, rst_n, (st_r == ST_DIVS) |-> (root_r != '0))
  `GVN_ASSERT(a_sum_normed, clk, rst_n, (st_r == ST_SQRT && it_r == 5'd0) |-> (sv_r[QW-1 -: 4] != 4'd0))
  `GVN_ASSERT_NEXT(a_out_wait, clk, rst_n, st_r == ST_OUT && out_valid_r && out_stall, st_r == ST_OUT)
endmodule

// ===== hdl/grid_vertex_normals.sv =====
`timescale 1ns / 1ps
`include "grid_vertex_normals_macros.svh"
// Vertex normals of a height-field grid streamed in raster order. A vertex beat is
// taken only when the previous vertex's normals are all computed; each vertex then
// yields zero to three normals. A vertex that yields none still passes through the
// queue and back end before the input is freed. Normals use the back end's single
// 33x33 multiplier (24 cross-product terms and 3 squares), a bit-serial square root
// and one 16-step divider reused for each component. The line store is one RAM of
// 3*MAX_COLS entries with no clearing pass after reset; grid registers are to be
// written only while idle (the block does not enforce it) and restart the frame.
module grid_vertex_normals #(
  parameter int MAX_COLS = gvn_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gvn_pkg::vtx_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gvn_pkg::nrm_t                 out_data,
  input  logic                          cfg_we,
  input  logic [gvn_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gvn_pkg::CFG_DW-1:0]    cfg_wdata
);
  localparam int AW = $clog2(3*MAX_COLS);
  localparam int VW = 3*gvn_pkg::CRD_W;

  logic          q_push, q_pop, q_empty, q_full, back_busy, ram_we;
  gvn_pkg::job_t q_job, q_head;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  gvn_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .hold      (!q_empty || back_busy || q_full),
    .q_push    (q_push),
    .q_job     (q_job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  gvn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_job),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  gvn_ram #(.WIDTH(VW), .DEPTH(3*MAX_COLS)) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gvn_back #(.MAX_COLS(MAX_COLS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // the line store must not change under a normal still being computed
  `GVN_ASSERT(a_accept_idle, clk, rst_n, (in_valid && !in_stall) |-> (q_empty && !back_busy))
endmodule

// ===== tb/gvn_normals_checker.sv =====
`timescale 1ns / 1ps
module gvn_normals_checker
  import gvn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  vtx_t                 in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  nrm_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  output int                   errors,
  output int                   pending
);
  localparam int DEPTH = 3 * MAX_COLS_DEF;

  logic signed [CRD_W-1:0] pts_x[DEPTH];
  logic signed [CRD_W-1:0] pts_y[DEPTH];
  logic signed [CRD_W-1:0] pts_z[DEPTH];
  int unsigned row_q, col_q;
  logic [ROW_W-1:0]  rows_reg;
  logic [GCOL_W-1:0] cols_reg;
  nrm_t normals_due[$];

  assign pending = normals_due.size();

  function automatic int slot(int unsigned r, int unsigned c);
    return (r % 3) * MAX_COLS_DEF + c;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic nrm_t normal_at(int unsigned r, int unsigned c,
                                     int unsigned rows, int unsigned cols);
    logic signed [127:0] p[3], e[4][3], acc[3];
    logic [127:0] mag[3];
    logic neg[3];
    logic [63:0] sm[3], sq, len, n;
    logic has[4];
    int nb, b, k, d, s;
    nrm_t o;
    has[0] = r > 0;
    has[1] = c > 0;
    has[2] = r + 1 < rows;
    has[3] = c + 1 < cols;
    p[0] = pts_x[slot(r, c)];
    p[1] = pts_y[slot(r, c)];
    p[2] = pts_z[slot(r, c)];
    for (k = 0; k < 4; k++) begin
      if (has[k]) begin
        case (k)
          0: nb = slot(r - 1, c);
          1: nb = slot(r, c - 1);
          2: nb = slot(r + 1, c);
          default: nb = slot(r, c + 1);
        endcase
        e[k][0] = pts_x[nb] - p[0];
        e[k][1] = pts_y[nb] - p[1];
        e[k][2] = pts_z[nb] - p[2];
      end
    end
    for (d = 0; d < 3; d++) acc[d] = 0;
    for (k = 0; k < 4; k++) begin
      if (has[k] && has[(k + 1) % 4]) begin
        acc[0] += e[k][1] * e[(k+1)%4][2] - e[k][2] * e[(k+1)%4][1];
        acc[1] += e[k][2] * e[(k+1)%4][0] - e[k][0] * e[(k+1)%4][2];
        acc[2] += e[k][0] * e[(k+1)%4][1] - e[k][1] * e[(k+1)%4][0];
      end
    end
    acc[0] = acc[0] * 3;
    acc[2] = acc[2] * 3;
    o = '0;
    o.out_row = r[ROW_W-1:0];
    o.out_col = c[OCOL_W-1:0];
    b = 0;
    for (d = 0; d < 3; d++) begin
      neg[d] = acc[d][127];
      mag[d] = neg[d] ? -acc[d] : acc[d];
      for (k = 0; k < 128; k++)
        if (mag[d][k] && k + 1 > b) b = k + 1;
    end
    if (b == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    s = b - 30;
    sq = 0;
    for (d = 0; d < 3; d++) begin
      sm[d] = s >= 0 ? 64'(mag[d] >> s) : 64'(mag[d] << (-s));
      sq += sm[d] * sm[d];
    end
    len = int_sqrt(sq);
    for (d = 0; d < 3; d++) begin
      n = (sm[d] * 16384 + len / 2) / len;
      if (n > 16384) n = 16384;
      n = neg[d] ? -n : n;
      case (d)
        0: o.norm_x = n[NRM_W-1:0];
        1: o.norm_y = n[NRM_W-1:0];
        default: o.norm_z = n[NRM_W-1:0];
      endcase
    end
    return o;
  endfunction

  task automatic predict_vertex(vtx_t v);
    int unsigned rows, cols, i, j, cnt;
    nrm_t res[3];
    rows = rows_reg == 0 ? 1 : rows_reg;
    cols = cols_reg == 0 ? 1 : (cols_reg > MAX_COLS_DEF ? MAX_COLS_DEF : cols_reg);
    i = row_q;
    j = col_q;
    cnt = 0;
    pts_x[slot(i, j)] = v.pos_x;
    pts_y[slot(i, j)] = v.pos_y;
    pts_z[slot(i, j)] = v.pos_z;
    if (i > 0) res[cnt++] = normal_at(i - 1, j, rows, cols);
    if (i + 1 == rows) begin
      if (j > 0) res[cnt++] = normal_at(i, j - 1, rows, cols);
      if (j + 1 == cols) res[cnt++] = normal_at(i, j, rows, cols);
    end
    for (int k = 0; k < cnt; k++) begin
      res[k].last_of_item = (k + 1 == cnt);
      normals_due.push_back(res[k]);
    end
    j++;
    if (j >= cols) begin
      j = 0;
      i++;
      if (i >= rows) i = 0;
    end
    row_q = i;
    col_q = j;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    nrm_t want;
    if (!rst_n) begin
      row_q = 0;
      col_q = 0;
      rows_reg = 1;
      cols_reg = 1;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_GRID_ROWS) begin
          rows_reg = cfg_wdata[ROW_W-1:0];
          row_q = 0;
          col_q = 0;
        end else if (cfg_idx == REG_GRID_COLS) begin
          cols_reg = cfg_wdata[GCOL_W-1:0];
          row_q = 0;
          col_q = 0;
        end
      end
      if (in_valid && !in_stall) predict_vertex(in_data);
      if (out_valid && !out_stall) begin
        if (normals_due.size() == 0) begin
          report("unexpected beat row", out_data.out_row, -1);
        end else begin
          want = normals_due.pop_front();
          if (out_data.out_row != want.out_row)
            report("out_row", out_data.out_row, want.out_row);
          if (out_data.out_col != want.out_col)
            report("out_col", out_data.out_col, want.out_col);
          if (out_data.norm_x != want.norm_x) report("norm_x", out_data.norm_x, want.norm_x);
          if (out_data.norm_y != want.norm_y) report("norm_y", out_data.norm_y, want.norm_y);
          if (out_data.norm_z != want.norm_z) report("norm_z", out_data.norm_z, want.norm_z);
          if (out_data.degenerate != want.degenerate)
            report("degenerate", out_data.degenerate, want.degenerate);
          if (out_data.last_of_item != want.last_of_item)
            report("last_of_item", out_data.last_of_item, want.last_of_item);
        end
      end
    end
  end

  initial errors = 0;
endmodule

// ===== tb/grid_vertex_normals_test.sv =====
`timescale 1ns / 1ps
module grid_vertex_normals_test;
  import gvn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int VX_EXTREME = 0;
  localparam int VX_SAME    = 1;
  localparam int VX_TERRAIN = 2;
  localparam int VX_MIXED   = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vtx_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nrm_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  int errors, pending;
  int vertices_sent = 0;
  bit quiet = 0;
  int step_sz;

  always #2 clk = ~clk;

  grid_vertex_normals u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_idx, .cfg_wdata
  );

  gvn_normals_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_idx, .cfg_wdata,
    .errors, .pending
  );

  always @(posedge clk) out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 7);

  function automatic vtx_t make_vertex(int mode, int r, int c);
    vtx_t v;
    case (mode)
      VX_EXTREME: begin
        v.pos_x = ((r + c) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        v.pos_y = (c % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        v.pos_z = (r % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      VX_SAME: v = {3{32'h0001_8000}};
      VX_TERRAIN: begin
        // regular grid in x/z, random height
        v.pos_x = c * step_sz + $urandom_range(255);
        v.pos_z = r * step_sz - $urandom_range(255);
        v.pos_y = $signed($urandom) >>> $urandom_range(31);
      end
      default: v = {$urandom, $urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_vertex(vtx_t v);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vertices_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // start a fresh grid shape and stream n vertices in raster order
  task automatic grid_pass(int rows, int cols, int n, int mode);
    int rr, cc, r_eff, c_eff;
    drain();
    write_reg(REG_GRID_ROWS, CFG_DW'(rows));
    write_reg(REG_GRID_COLS, CFG_DW'(cols));
    r_eff = rows == 0 ? 1 : rows;
    c_eff = (cols % 2048) == 0 ? 1 : ((cols % 2048) > 1024 ? 1024 : cols % 2048);
    rr = 0;
    cc = 0;
    repeat (n) begin
      send_vertex(make_vertex(mode == VX_TERRAIN && $urandom_range(9) == 0 ? VX_MIXED : mode,
                              rr, cc));
      if (++cc >= c_eff) begin
        cc = 0;
        if (++rr >= r_eff) rr = 0;
      end
    end
  endtask

  initial begin
    int rows, cols, n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    step_sz = 32'h0001_0000;
    // reset shape: lone vertex, no neighbors
    send_vertex(make_vertex(VX_EXTREME, 0, 0));
    send_vertex(make_vertex(VX_MIXED, 0, 0));
    grid_pass(0, 0, 1, VX_EXTREME);
    grid_pass(3, 3, 9, VX_EXTREME);
    grid_pass(2, 2, 4, VX_SAME);
    // unused index leaves the frame position alone
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_vertex(make_vertex(VX_SAME, 0, 0));
    send_vertex(make_vertex(VX_SAME, 1, 0));
    grid_pass(1, 16'hFFFF, 6, VX_EXTREME);
    grid_pass(16'hFFFF, 1, 4, VX_EXTREME);
    while (vertices_sent < 200) begin
      quiet = vertices_sent > 100 && vertices_sent < 150;
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 8);
      step_sz = $urandom_range(1, 32'h0040_0000);
      n = ($urandom_range(3) == 0) ? $urandom_range(1, rows * cols)
                                   : rows * cols * $urandom_range(1, 2);
      grid_pass(rows, cols, n, $urandom_range(4) == 0 ? VX_MIXED : VX_TERRAIN);
    end
    quiet = 0;
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
